>>> hdl/nbg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nbg_pkg
// shared types, sizes and helpers for the n-body gravity stepper
// ----------------------------------------------------------------------------
package nbg_pkg;

    localparam int MAX_BODIES   = 64;
    localparam int FRAC_BITS    = 16;
    localparam int RESULT_LIMIT = 64;

    localparam int CNT_W      = $clog2(MAX_BODIES + 1);
    localparam int OUT_IDX_W  = 6;
    localparam int GM_W       = 24;
    localparam int NUM_W      = GM_W + 32 + 3 * FRAC_BITS;
    localparam int DEN_W      = 96;
    localparam int DSH_W      = DEN_W + 31;
    localparam int DIV_W      = (NUM_W > DSH_W) ? NUM_W : DSH_W;
    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 136;
    localparam int ADDR_W     = 4;

    localparam logic [1:0] REG_GRAVITY = 2'd0;
    localparam logic [1:0] REG_STEP    = 2'd1;
    localparam logic [1:0] REG_COUNT   = 2'd2;

    localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7fff_ffff;
    localparam logic signed [63:0] SAT_MIN = 64'shffff_ffff_8000_0000;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic        [7:0]  mass;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
    } t_body;

    typedef struct packed {
        logic               done;
        logic signed [32:0] cx;
        logic signed [32:0] cy;
    } t_pair_res;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC_HEAD,
        ST_SCAN,
        ST_PAIR,
        ST_ACC_WR,
        ST_ACC_NEXT,
        ST_UPD_HEAD,
        ST_U_MA,
        ST_U_V,
        ST_U_MV,
        ST_U_P,
        ST_U_EMIT,
        ST_UPD_NEXT
    } t_state;

    typedef enum logic [2:0] {
        P_IDLE,
        P_SQX,
        P_SQY,
        P_ROOT,
        P_DLO,
        P_DHI,
        P_DIV,
        P_DONE
    } t_pstate;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[31:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[31:0];
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hdl/nbody_gravity_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nbody_gravity_step
// direct-sum 2d gravity stepper over a rotating ring of body cells
// ----------------------------------------------------------------------------
// load beat: accepted while idle, writes the body cell its index names; no result
// tick beat: an acceleration pass runs the pair unit for each interacting pair
//   (32-step root, 32-step divide, both skipped for a coincident pair), then an
//   update pass steps each body in use and may wait on output stalls; each pass rotates past unused slots
// one result beat per body in use; the next beat is taken once back idle
// reset: synchronous, clears control and restores register defaults;
//   body cells hold undefined values until loaded
// ----------------------------------------------------------------------------
module nbody_gravity_step import nbg_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // index[5:0] pos_x[37:6] pos_y[69:38] vel_x[101:70] vel_y[133:102] mass[141:134]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // func
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // index[5:0] pos_x[37:6] pos_y[69:38] vel_x[101:70] vel_y[133:102]
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic                       m_tlast
);

    t_state r_state, n_state;

    logic [15:0]      r_g, r_dt;
    logic [6:0]       r_count;
    logic [CNT_W-1:0] r_i, r_n;
    logic [CNT_W:0]   r_j;

    logic signed [31:0] r_pix, r_piy, r_accx, r_accy;
    logic signed [48:0] r_mvx, r_mvy, r_mpx, r_mpy;
    logic signed [31:0] r_vx, r_vy, r_px, r_py;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_last;

    t_body     w_body [MAX_BODIES];
    t_body     w_head, w_wr_body;
    logic      w_wr [MAX_BODIES];
    t_pair_res w_pres;

    logic w_in_fire, w_load, w_rot, w_head_wr, w_pair_start, w_emit, w_cfg_wr, w_hit;
    logic [CNT_W:0]     w_sum, w_tag;
    logic [CNT_W-1:0]   w_n_calc;
    logic signed [16:0] w_dt_s;

    assign w_head    = w_body[0];
    assign w_in_fire = s_tvalid && s_tready;
    assign w_load    = w_in_fire && !s_tuser;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_dt_s    = $signed({1'b0, r_dt});
    assign w_sum     = (CNT_W+1)'(r_i) + r_j;
    assign w_tag     = w_sum - (CNT_W+1)'(MAX_BODIES);

    // second turn of the ring visits bodies in ascending index order
    assign w_hit = (w_sum >= (CNT_W+1)'(MAX_BODIES)) && (w_sum < (CNT_W+1)'(2 * MAX_BODIES))
                   && (w_tag < (CNT_W+1)'(r_n)) && (w_tag != (CNT_W+1)'(r_i));

    always_comb begin
        w_n_calc = CNT_W'(r_count);
        if (32'(r_count) > MAX_BODIES) w_n_calc = CNT_W'(MAX_BODIES);
        if (32'(w_n_calc) > RESULT_LIMIT) w_n_calc = CNT_W'(RESULT_LIMIT);
    end

    // body ring, head at cell 0
    for (genvar k = 0; k < MAX_BODIES; k++) begin : g_ring
        assign w_wr[k] = (w_load && 32'(s_tdata[5:0]) == k) || (k == 0 && w_head_wr);
        nbg_cell u_cell (
            .i_clk     (i_clk),
            .i_shift   (w_rot),
            .i_wr      (w_wr[k]),
            .i_wr_body (w_wr_body),
            .i_next    (w_body[(k + 1) % MAX_BODIES]),
            .o_body    (w_body[k])
        );
    end

    nbg_pair u_pair (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_pair_start),
        .i_g     (r_g),
        .i_mass  (w_head.mass),
        .i_pix   (r_pix),
        .i_piy   (r_piy),
        .i_pjx   (w_head.px),
        .i_pjy   (w_head.py),
        .o_res   (w_pres)
    );

    always_comb begin
        w_wr_body = w_head;
        case (r_state)
            ST_IDLE: begin
                w_wr_body.px   = $signed(s_tdata[37:6]);
                w_wr_body.py   = $signed(s_tdata[69:38]);
                w_wr_body.vx   = $signed(s_tdata[101:70]);
                w_wr_body.vy   = $signed(s_tdata[133:102]);
                w_wr_body.mass = s_tdata[141:134];
                w_wr_body.ax   = 32'sd0;
                w_wr_body.ay   = 32'sd0;
            end
            ST_ACC_WR: begin
                w_wr_body.ax = r_accx;
                w_wr_body.ay = r_accy;
            end
            default: begin
                w_wr_body.px = r_px;
                w_wr_body.py = r_py;
                w_wr_body.vx = r_vx;
                w_wr_body.vy = r_vy;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_in_fire && s_tuser) n_state = ST_ACC_HEAD;
            ST_ACC_HEAD: begin
                if (r_i == CNT_W'(MAX_BODIES)) n_state = ST_UPD_HEAD;
                else if (r_i < r_n) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_j == (CNT_W+1)'(2 * MAX_BODIES)) n_state = ST_ACC_WR;
                else if (w_hit) n_state = ST_PAIR;
            end
            ST_PAIR:     if (w_pres.done) n_state = ST_SCAN;
            ST_ACC_WR:   n_state = ST_ACC_NEXT;
            ST_ACC_NEXT: n_state = ST_ACC_HEAD;
            ST_UPD_HEAD: begin
                if (r_i == CNT_W'(MAX_BODIES)) n_state = ST_IDLE;
                else if (r_i < r_n) n_state = ST_U_MA;
            end
            ST_U_MA:     n_state = ST_U_V;
            ST_U_V:      n_state = ST_U_MV;
            ST_U_MV:     n_state = ST_U_P;
            ST_U_P:      n_state = ST_U_EMIT;
            ST_U_EMIT:   if (!r_out_valid || m_tready) n_state = ST_UPD_NEXT;
            ST_UPD_NEXT: n_state = ST_UPD_HEAD;
            default:     n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready     = 1'b0;
        w_rot        = 1'b0;
        w_head_wr    = 1'b0;
        w_pair_start = 1'b0;
        w_emit       = 1'b0;
        case (r_state)
            ST_IDLE: s_tready = 1'b1;
            ST_ACC_HEAD: begin
                w_rot = (r_i != CNT_W'(MAX_BODIES)) && !(r_i < r_n);
            end
            ST_SCAN: begin
                if (r_j != (CNT_W+1)'(2 * MAX_BODIES)) begin
                    if (w_hit) w_pair_start = 1'b1;
                    else w_rot = 1'b1;
                end
            end
            ST_PAIR:     w_rot = w_pres.done;
            ST_ACC_WR:   w_head_wr = 1'b1;
            ST_ACC_NEXT: w_rot = 1'b1;
            ST_UPD_HEAD: begin
                w_rot = (r_i != CNT_W'(MAX_BODIES)) && !(r_i < r_n);
            end
            ST_U_EMIT: begin
                w_emit    = !r_out_valid || m_tready;
                w_head_wr = w_emit;
            end
            ST_UPD_NEXT: w_rot = 1'b1;
            default: begin
            end
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_n         <= '0;
            r_g         <= 16'd10000;
            r_dt        <= 16'd655;
            r_count     <= 7'd1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) begin
                case (paddr[3:2])
                    REG_GRAVITY: r_g     <= pwdata[15:0];
                    REG_STEP:    r_dt    <= pwdata[15:0];
                    REG_COUNT:   r_count <= pwdata[6:0];
                    default: begin
                    end
                endcase
            end
            if (w_in_fire && s_tuser) begin
                r_n <= w_n_calc;
                r_i <= '0;
            end
            case (r_state)
                ST_ACC_HEAD: begin
                    if (r_i == CNT_W'(MAX_BODIES)) r_i <= '0;
                    else if (w_rot) r_i <= r_i + 1'b1;
                    r_j <= '0;
                end
                ST_SCAN:     if (w_rot) r_j <= r_j + 1'b1;
                ST_PAIR:     if (w_rot) r_j <= r_j + 1'b1;
                ST_ACC_NEXT: r_i <= r_i + 1'b1;
                ST_UPD_HEAD: if (w_rot) r_i <= r_i + 1'b1;
                ST_UPD_NEXT: r_i <= r_i + 1'b1;
                default: begin
                end
            endcase
            if (w_emit) r_out_valid <= 1'b1;
            else if (m_tready) r_out_valid <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_ACC_HEAD: begin
                r_pix  <= w_head.px;
                r_piy  <= w_head.py;
                r_accx <= 32'sd0;
                r_accy <= 32'sd0;
            end
            ST_PAIR: begin
                if (w_pres.done) begin
                    r_accx <= sat32(64'(r_accx) + 64'(w_pres.cx));
                    r_accy <= sat32(64'(r_accy) + 64'(w_pres.cy));
                end
            end
            ST_U_MA: begin
                r_mvx <= w_dt_s * w_head.ax;
                r_mvy <= w_dt_s * w_head.ay;
            end
            ST_U_V: begin
                r_vx <= sat32(64'(w_head.vx) + 64'(r_mvx >>> 16));
                r_vy <= sat32(64'(w_head.vy) + 64'(r_mvy >>> 16));
            end
            ST_U_MV: begin
                r_mpx <= w_dt_s * r_vx;
                r_mpy <= w_dt_s * r_vy;
            end
            ST_U_P: begin
                r_px <= sat32(64'(w_head.px) + 64'(r_mpx >>> 16));
                r_py <= sat32(64'(w_head.py) + 64'(r_mpy >>> 16));
            end
            default: begin
            end
        endcase
        if (w_emit) begin
            r_out_data <= {2'b00, r_vy, r_vx, r_py, r_px, OUT_IDX_W'(r_i)};
            r_out_last <= (r_i == r_n - 1'b1);
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_GRAVITY: prdata = {16'b0, r_g};
            REG_STEP:    prdata = {16'b0, r_dt};
            REG_COUNT:   prdata = {25'b0, r_count};
            default:     prdata = 32'b0;
        endcase
    end

    assign pready   = 1'b1;
    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;
    assign m_tlast  = r_out_last;

endmodule
`default_nettype wire

>>> hdl/nbg_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nbg_cell
// one body slot of the rotating body ring
// ----------------------------------------------------------------------------
module nbg_cell import nbg_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_shift,
    input  wire logic  i_wr,
    input  wire t_body i_wr_body,
    input  wire t_body i_next,
    output t_body      o_body
);

    t_body r_body;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_body <= i_wr_body;
        end else if (i_shift) begin
            r_body <= i_next;
        end
    end

    assign o_body = r_body;

endmodule
`default_nettype wire

>>> hdl/nbg_pair.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nbg_pair
// pair interaction unit: distance, iterative root, iterative divide
// ----------------------------------------------------------------------------
module nbg_pair import nbg_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic        [15:0] i_g,
    input  wire logic        [7:0]  i_mass,
    input  wire logic signed [31:0] i_pix,
    input  wire logic signed [31:0] i_piy,
    input  wire logic signed [31:0] i_pjx,
    input  wire logic signed [31:0] i_pjy,
    output t_pair_res               o_res
);

    t_pstate r_pstate, n_pstate;
    logic [4:0] r_cnt;

    logic              r_negx, r_negy;
    logic [31:0]       r_ux, r_uy;
    logic [GM_W-1:0]   r_gm;
    logic [63:0]       r_d2;
    logic [GM_W+31:0]  r_nx, r_ny;
    logic [63:0]       r_rsrc;
    logic [35:0]       r_rrem;
    logic [31:0]       r_root;
    logic [63:0]       r_dlo;
    logic [DIV_W-1:0]  r_dsh, r_remx, r_remy;
    logic [31:0]       r_qx, r_qy;

    logic signed [32:0] w_dxw, w_dyw;
    logic signed [31:0] w_dx, w_dy;
    logic [63:0]        w_d2_sum;
    logic [35:0]        w_rsh, w_trial;
    logic [63:0]        w_dhi_p;
    logic [DEN_W-1:0]   w_dfull;
    logic               w_gex, w_gey;
    logic [31:0]        w_magx, w_magy;

    assign w_dxw    = 33'(i_pjx) - 33'(i_pix);
    assign w_dyw    = 33'(i_pjy) - 33'(i_piy);
    assign w_dx     = sat32(64'(w_dxw));
    assign w_dy     = sat32(64'(w_dyw));
    assign w_d2_sum = r_d2 + r_uy * r_uy;
    assign w_rsh    = {r_rrem[33:0], r_rsrc[63:62]};
    assign w_trial  = {2'b00, r_root, 2'b01};
    assign w_dhi_p  = r_d2[63:32] * r_root;
    assign w_dfull  = {w_dhi_p, 32'b0} + {32'b0, r_dlo};
    assign w_gex    = (r_remx >= r_dsh);
    assign w_gey    = (r_remy >= r_dsh);

    // quotient at or above 2^31 is limited to 2^31
    assign w_magx = r_qx[31] ? {1'b1, 31'b0} : r_qx;
    assign w_magy = r_qy[31] ? {1'b1, 31'b0} : r_qy;

    always_comb begin
        n_pstate = r_pstate;
        case (r_pstate)
            P_IDLE: if (i_start) n_pstate = P_SQX;
            P_SQX:  n_pstate = P_SQY;
            P_SQY:  n_pstate = (r_ux == 32'd0 && r_uy == 32'd0) ? P_DONE : P_ROOT;
            P_ROOT: if (r_cnt == 5'd0) n_pstate = P_DLO;
            P_DLO:  n_pstate = P_DHI;
            P_DHI:  n_pstate = P_DIV;
            P_DIV:  if (r_cnt == 5'd0) n_pstate = P_DONE;
            P_DONE: n_pstate = P_IDLE;
            default: n_pstate = P_IDLE;
        endcase
    end

    always_comb begin
        o_res.done = (r_pstate == P_DONE);
        o_res.cx   = r_negx ? -$signed({1'b0, w_magx}) : $signed({1'b0, w_magx});
        o_res.cy   = r_negy ? -$signed({1'b0, w_magy}) : $signed({1'b0, w_magy});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pstate <= P_IDLE;
            r_cnt    <= 5'd0;
        end else begin
            r_pstate <= n_pstate;
            case (r_pstate)
                P_SQY:   r_cnt <= 5'd31;
                P_ROOT:  r_cnt <= r_cnt - 5'd1;
                P_DHI:   r_cnt <= 5'd31;
                P_DIV:   r_cnt <= r_cnt - 5'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_pstate)
            P_IDLE: begin
                r_negx <= w_dx[31];
                r_negy <= w_dy[31];
                r_ux   <= w_dx[31] ? 32'(-w_dx) : 32'(w_dx);
                r_uy   <= w_dy[31] ? 32'(-w_dy) : 32'(w_dy);
                r_gm   <= i_g * i_mass;
            end
            P_SQX: begin
                r_d2 <= r_ux * r_ux;
                r_nx <= r_gm * r_ux;
            end
            P_SQY: begin
                r_d2   <= w_d2_sum;
                r_rsrc <= w_d2_sum;
                r_ny   <= r_gm * r_uy;
                r_rrem <= 36'd0;
                r_root <= 32'd0;
                r_qx   <= 32'd0;
                r_qy   <= 32'd0;
            end
            P_ROOT: begin
                r_rsrc <= {r_rsrc[61:0], 2'b00};
                if (w_rsh >= w_trial) begin
                    r_rrem <= w_rsh - w_trial;
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_rrem <= w_rsh;
                    r_root <= {r_root[30:0], 1'b0};
                end
            end
            P_DLO: begin
                r_dlo <= r_d2[31:0] * r_root;
            end
            P_DHI: begin
                r_dsh  <= DIV_W'(w_dfull) << 31;
                r_remx <= DIV_W'(r_nx) << (3 * FRAC_BITS);
                r_remy <= DIV_W'(r_ny) << (3 * FRAC_BITS);
            end
            P_DIV: begin
                r_dsh  <= r_dsh >> 1;
                r_remx <= w_gex ? r_remx - r_dsh : r_remx;
                r_remy <= w_gey ? r_remy - r_dsh : r_remy;
                r_qx   <= {r_qx[30:0], w_gex};
                r_qy   <= {r_qy[30:0], w_gey};
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire
